// ===== src/kae_pkg.sv =====
// shared types, key codes, fix tables and microcode word layout for the keystroke autocorrect engine
// no dependencies; imported by kae_sequencer, kae_datapath and keystroke_autocorrect_engine
package kae_pkg;

  // default word buffer size (holds one letter less than this)
  localparam int WordBufferSize = 32;

  // fix table geometry
  localparam int TableEntries = 10;
  localparam int TypoMaxLen   = 10;
  localparam int FixMaxLen    = 11;

  localparam logic [4:0] MinWordLenReset = 5'd3;

  typedef logic [7:0] hid_code_t;

  // hid usage codes
  localparam hid_code_t CodeA     = 8'd4;
  localparam hid_code_t CodeZ     = 8'd29;
  localparam hid_code_t CodeRet   = 8'd40;
  localparam hid_code_t CodeBspc  = 8'd42;
  localparam hid_code_t CodeTab   = 8'd43;
  localparam hid_code_t CodeSpace = 8'd44;
  localparam hid_code_t CodeComma = 8'd54;
  localparam hid_code_t CodeDot   = 8'd55;

  localparam logic [7:0] AsciiA = 8'h61;

  // typo words and their fixes, text right-justified in each entry
  localparam logic [8*TypoMaxLen-1:0] TypoText [TableEntries] = '{
    "teh", "adn", "taht", "recieve", "seperate",
    "occured", "acheive", "beleive", "definately", "accomodate"
  };
  localparam logic [3:0] TypoLen [TableEntries] = '{
    4'd3, 4'd3, 4'd4, 4'd7, 4'd8, 4'd7, 4'd7, 4'd7, 4'd10, 4'd10
  };
  localparam logic [8*FixMaxLen-1:0] FixText [TableEntries] = '{
    "the", "and", "that", "receive", "separate",
    "occurred", "achieve", "believe", "definitely", "accommodate"
  };
  localparam logic [3:0] FixLen [TableEntries] = '{
    4'd3, 4'd3, 4'd4, 4'd7, 4'd8, 4'd8, 4'd7, 4'd7, 4'd10, 4'd11
  };

  // letter index (0 = a) of a typo word at a position, counted from the start
  function automatic logic [4:0] typo_letter(input logic [3:0] entry, input logic [3:0] pos);
    logic [7:0] ch;
    ch = AsciiA;
    if (pos < TypoLen[entry]) begin
      ch = 8'(TypoText[entry] >> (8 * (int'(TypoLen[entry]) - 1 - int'(pos))));
    end
    return 5'(ch - AsciiA);
  endfunction

  // letter index (0 = a) of a fix word at a position, counted from the start
  function automatic logic [4:0] fix_letter(input logic [3:0] entry, input logic [3:0] pos);
    logic [7:0] ch;
    ch = AsciiA;
    if (pos < FixLen[entry]) begin
      ch = 8'(FixText[entry] >> (8 * (int'(FixLen[entry]) - 1 - int'(pos))));
    end
    return 5'(ch - AsciiA);
  endfunction

  // datapath operation selected by the current control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FETCH,
    OP_LETTER,
    OP_BSPC,
    OP_CLEAR,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_PICK,
    OP_EMIT_BS,
    OP_EMIT_FIX
  } uop_t;

  // jump condition of a control word
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_BEAT,
    C_RELEASE,
    C_LETTER,
    C_BSPC,
    C_NOT_BOUNDARY,
    C_NO_CHECK,
    C_SCAN_MORE,
    C_NO_HIT,
    C_BS_BUSY,
    C_FIX_BUSY
  } cond_t;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // status from the datapath that the jump conditions test
  typedef struct packed {
    logic beat;
    logic release_key;
    logic letter;
    logic bspc;
    logic boundary;
    logic check_ok;
    logic scan_more;
    logic hit;
    logic bs_done;
    logic fix_done;
  } dp_flags_t;

endpackage

// ===== src/keystroke_autocorrect_engine.sv =====
// top level of the keystroke autocorrect engine
// depends on kae_pkg, kae_sequencer and kae_datapath
//
// Takes one key beat at a time and answers with a burst of key events only when a
// word ending in space, period, comma, return or tab matches one of ten known typos.
// A small microcoded sequencer steps a plain datapath, so a beat is taken only
// while the sequencer sits at its fetch step. A checked boundary key scans the typed
// letters with one store read per cycle, and a corrected word is sent as one
// backspace per typed letter and then the letters of the fix, one event per cycle
// through the single output register while the output does not stall. The last
// event of a burst is flagged and the next key is taken while it waits at the
// output. No clearing pass is needed after reset.
module keystroke_autocorrect_engine #(
  parameter int WORD_BUFFER_SIZE = kae_pkg::WordBufferSize
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] key_code,
  input  logic       key_down,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_code,
  output logic       out_down,
  output logic       out_last
);
  import kae_pkg::*;

  uop_t      op;
  dp_flags_t flags;

  // control sequencer
  kae_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .op       (op),
    .in_stall (in_stall)
  );

  // word buffer, scan and event output
  kae_datapath #(
    .WORD_BUFFER_SIZE (WORD_BUFFER_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .key_code  (key_code),
    .key_down  (key_down),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_code  (out_code),
    .out_down  (out_down),
    .out_last  (out_last),
    .op        (op),
    .flags     (flags)
  );

endmodule

// ===== src/kae_sequencer.sv =====
// microcode sequencer: step counter, control store and jump logic
// depends on kae_pkg for the control word layout and datapath flags
module kae_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  kae_pkg::dp_flags_t flags,
  output kae_pkg::uop_t     op,
  output logic              in_stall
);
  import kae_pkg::*;

  // step addresses that are jump targets
  localparam upc_t UpcFetch  = 4'd0;
  localparam upc_t UpcScan   = 4'd6;
  localparam upc_t UpcBs     = 4'd8;
  localparam upc_t UpcFix    = 4'd9;
  localparam upc_t UpcClear  = 4'd10;
  localparam upc_t UpcLetter = 4'd11;
  localparam upc_t UpcBspc   = 4'd12;

  // control store
  localparam uword_t Ucode [16] = '{
    '{OP_FETCH,     C_NO_BEAT,      UpcFetch},   // wait for a key beat
    '{OP_NONE,      C_RELEASE,      UpcFetch},   // releases do nothing
    '{OP_NONE,      C_LETTER,       UpcLetter},
    '{OP_NONE,      C_BSPC,         UpcBspc},
    '{OP_NONE,      C_NOT_BOUNDARY, UpcClear},   // any other key ends the word
    '{OP_SCAN_INIT, C_NO_CHECK,     UpcClear},
    '{OP_SCAN,      C_SCAN_MORE,    UpcScan},    // one letter per step
    '{OP_PICK,      C_NO_HIT,       UpcClear},
    '{OP_EMIT_BS,   C_BS_BUSY,      UpcBs},      // erase typed letters
    '{OP_EMIT_FIX,  C_FIX_BUSY,     UpcFix},     // type the fix
    '{OP_CLEAR,     C_ALWAYS,       UpcFetch},
    '{OP_LETTER,    C_ALWAYS,       UpcFetch},
    '{OP_BSPC,      C_ALWAYS,       UpcFetch},
    '{OP_NONE,      C_ALWAYS,       UpcFetch},
    '{OP_NONE,      C_ALWAYS,       UpcFetch},
    '{OP_NONE,      C_ALWAYS,       UpcFetch}
  };

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   take;

  assign uw = Ucode[upc];

  // jump condition and next step
  always_comb begin
    case (uw.cond)
      C_ALWAYS:       take = 1'b1;
      C_NO_BEAT:      take = !flags.beat;
      C_RELEASE:      take = flags.release_key;
      C_LETTER:       take = flags.letter;
      C_BSPC:         take = flags.bspc;
      C_NOT_BOUNDARY: take = !flags.boundary;
      C_NO_CHECK:     take = !flags.check_ok;
      C_SCAN_MORE:    take = flags.scan_more;
      C_NO_HIT:       take = !flags.hit;
      C_BS_BUSY:      take = !flags.bs_done;
      C_FIX_BUSY:     take = !flags.fix_done;
      default:        take = 1'b0;
    endcase
    upc_next = take ? uw.target : upc + 4'd1;
  end

  // control outputs of the current step
  always_comb begin
    op       = uw.op;
    in_stall = (uw.op != OP_FETCH);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UpcFetch;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== src/kae_datapath.sv =====
// datapath: key register, letter store, word count, typo scan mask and event output register
// depends on kae_pkg for key codes, fix tables and the operation codes from kae_sequencer
module kae_datapath #(
  parameter int WORD_BUFFER_SIZE = kae_pkg::WordBufferSize
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  input  logic [7:0]         key_code,
  input  logic               key_down,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         out_code,
  output logic               out_down,
  output logic               out_last,
  input  kae_pkg::uop_t      op,
  output kae_pkg::dp_flags_t flags
);
  import kae_pkg::*;

  localparam int Depth = WORD_BUFFER_SIZE - 1;
  localparam int CW    = $clog2(WORD_BUFFER_SIZE);
  localparam int AW    = $clog2(Depth);
  localparam logic [CW-1:0] CntMax = CW'(Depth);

  logic [7:0]              key_code_r;
  logic                    key_down_r;
  logic [4:0]              min_word_len;
  logic [CW-1:0]           cnt;
  logic                    inword;
  logic [4:0]              idx;
  logic [TableEntries-1:0] mask;
  logic [TableEntries-1:0] match;
  logic [3:0]              sel;
  logic [3:0]              first_hit;
  logic [4:0]              mem [Depth];
  logic [4:0]              rdata;
  logic [AW-1:0]           raddr;
  logic [4:0]              bs_end;
  logic [4:0]              fix_end;
  logic                    out_free;
  logic                    is_letter;
  logic                    is_boundary;
  logic                    room;

  // key classes
  assign is_letter   = key_code_r inside {[CodeA:CodeZ]};
  assign is_boundary = key_code_r inside {CodeSpace, CodeDot, CodeComma, CodeRet, CodeTab};
  assign room        = (cnt < CntMax);

  // last event index of each emit phase (words to check are at most ten letters)
  assign bs_end   = 5'({cnt[3:0], 1'b0} - 5'd1);
  assign fix_end  = 5'({FixLen[sel], 1'b0} - 5'd1);
  assign out_free = !out_valid || !out_stall;

  // store read address: next letter of the scan
  always_comb begin
    case (op)
      OP_SCAN: raddr = AW'(idx + 5'd1);
      default: raddr = '0;
    endcase
  end

  // compare the current letter against every typo at this position
  always_comb begin
    for (int e = 0; e < TableEntries; e++) begin
      match[e] = (typo_letter(4'(e), idx[3:0]) == rdata);
    end
  end

  // lowest surviving entry
  always_comb begin
    first_hit = '0;
    for (int e = TableEntries - 1; e >= 0; e--) begin
      if (mask[e]) first_hit = 4'(e);
    end
  end

  // flags for the sequencer
  always_comb begin
    flags.beat        = in_valid;
    flags.release_key = !key_down_r;
    flags.letter      = is_letter;
    flags.bspc        = (key_code_r == CodeBspc);
    flags.boundary    = is_boundary;
    flags.check_ok    = inword && (int'(cnt) >= int'(min_word_len))
                        && (int'(cnt) <= TypoMaxLen);
    flags.scan_more   = (int'(idx) + 1 < int'(cnt));
    flags.hit         = |mask;
    flags.bs_done     = out_free && (idx == bs_end);
    flags.fix_done    = out_free && (idx == fix_end);
  end

  // letter store
  always_ff @(posedge clk) begin
    if (op == OP_LETTER && room) begin
      mem[AW'(cnt)] <= 5'(key_code_r - CodeA);
    end
    rdata <= mem[raddr];
  end

  // control state: register, word count, output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      min_word_len <= MinWordLenReset;
      cnt          <= '0;
      inword       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) min_word_len <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (op)
        OP_LETTER: begin
          if (room) begin
            cnt    <= cnt + CW'(1);
            inword <= 1'b1;
          end
        end
        OP_BSPC: begin
          if (cnt != '0) cnt <= cnt - CW'(1);
          if (cnt <= CW'(1)) inword <= 1'b0;
        end
        OP_CLEAR: begin
          cnt    <= '0;
          inword <= 1'b0;
        end
        OP_EMIT_BS, OP_EMIT_FIX: begin
          if (out_free) out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload: key beat, scan state, output event
  always_ff @(posedge clk) begin
    case (op)
      OP_FETCH: begin
        if (in_valid) begin
          key_code_r <= key_code;
          key_down_r <= key_down;
        end
      end
      OP_SCAN_INIT: begin
        idx <= '0;
        for (int e = 0; e < TableEntries; e++) begin
          mask[e] <= (int'(TypoLen[e]) == int'(cnt));
        end
      end
      OP_SCAN: begin
        idx  <= idx + 5'd1;
        mask <= mask & match;
      end
      OP_PICK: begin
        idx <= '0;
        sel <= first_hit;
      end
      OP_EMIT_BS: begin
        if (out_free) begin
          out_code <= CodeBspc;
          out_down <= !idx[0];
          out_last <= 1'b0;
          idx      <= flags.bs_done ? 5'd0 : idx + 5'd1;
        end
      end
      OP_EMIT_FIX: begin
        if (out_free) begin
          out_code <= CodeA + {3'b000, fix_letter(sel, idx[4:1])};
          out_down <= !idx[0];
          out_last <= (idx == fix_end);
          idx      <= idx + 5'd1;
        end
      end
      default: ;
    endcase
  end

  // word count stays within the buffer
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= CntMax)
    else $error("word count beyond buffer");

  // a word is open exactly while letters are held
  a_inword_cnt: assert property (@(posedge clk) disable iff (rst) inword == (cnt != '0))
    else $error("word flag out of step with letter count");

  // typos are distinct, so at most one entry survives the scan
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (op == OP_PICK) |-> $onehot0(mask))
    else $error("more than one typo matched");

  // the final fix event is presented with the last mark
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT_FIX && flags.fix_done) |=> (out_valid && out_last))
    else $error("final fix event missing last mark");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for keystroke_autocorrect_engine: random key beats in, event bursts out
// depends on kae_pkg and the engine rtl; predicts every burst from its own word tracker
`timescale 1ns / 1ps

module tb;
  import kae_pkg::*;

  localparam int WordSlots = WordBufferSize - 1;
  localparam int SettleCycles = 80;
  localparam int HoldCycles = 400;
  localparam int GapPct = 34;

  typedef struct packed {
    hid_code_t code;
    logic      down;
  } key_beat_t;

  typedef struct packed {
    hid_code_t code;
    logic      down;
    logic      last;
  } key_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [4:0] cfg_data = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] key_code = 8'd0;
  logic       key_down = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_code;
  logic       out_down;
  logic       out_last;

  // typo words and the words that replace them
  string typo_words [TableEntries] = '{
    "teh", "adn", "taht", "recieve", "seperate",
    "occured", "acheive", "beleive", "definately", "accomodate"
  };
  string fix_words [TableEntries] = '{
    "the", "and", "that", "receive", "separate",
    "occurred", "achieve", "believe", "definitely", "accommodate"
  };
  hid_code_t boundary_keys [5] = '{CodeSpace, CodeDot, CodeComma, CodeRet, CodeTab};

  // word tracker state
  logic [4:0] word_letters [WordSlots];
  int         word_len = 0;
  bit         in_word = 1'b0;
  int         min_len = int'(MinWordLenReset);

  key_beat_t  pending_beats [$];
  key_event_t expected_events [$];
  key_beat_t  cur_beat;
  key_event_t want;

  int  beats_queued = 0;
  int  beats_sent = 0;
  int  events_checked = 0;
  int  fixes_predicted = 0;
  int  mismatches = 0;
  int  settings_used = 0;
  int  hold_left = 0;
  bit  hold_phase = 1'b0;
  bit  hold_done = 1'b0;
  bit  steady = 1'b0;

  keystroke_autocorrect_engine DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key_code(key_code),
    .key_down(key_down),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_code(out_code),
    .out_down(out_down),
    .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected events for one accepted key beat
  task automatic predict_key(input key_beat_t beat);
    bit    hit;
    string w;
    string fix;
    hit = 1'b0;
    if (!beat.down) return;
    if (beat.code >= CodeA && beat.code <= CodeZ) begin
      if (word_len < WordSlots) begin
        word_letters[word_len] = 5'(beat.code - CodeA);
        word_len++;
        in_word = 1'b1;
      end
    end else if (beat.code == CodeSpace || beat.code == CodeDot || beat.code == CodeComma ||
                 beat.code == CodeRet || beat.code == CodeTab) begin
      if (in_word && word_len >= min_len) begin
        for (int e = 0; e < TableEntries && !hit; e++) begin
          w = typo_words[e];
          if (w.len() == word_len) begin
            hit = 1'b1;
            for (int i = 0; i < word_len; i++) begin
              if (word_letters[i] != 5'(8'(w[i]) - AsciiA)) hit = 1'b0;
            end
            if (hit) fix = fix_words[e];
          end
        end
        if (hit) begin
          // erase what was typed, then type the fix
          for (int i = 0; i < word_len; i++) begin
            expected_events.push_back(key_event_t'{CodeBspc, 1'b1, 1'b0});
            expected_events.push_back(key_event_t'{CodeBspc, 1'b0, 1'b0});
          end
          for (int i = 0; i < fix.len(); i++) begin
            expected_events.push_back(key_event_t'{8'(CodeA + (8'(fix[i]) - AsciiA)), 1'b1, 1'b0});
            expected_events.push_back(key_event_t'{8'(CodeA + (8'(fix[i]) - AsciiA)), 1'b0, 1'b0});
          end
          expected_events[expected_events.size() - 1].last = 1'b1;
          fixes_predicted++;
        end
      end
      word_len = 0;
      in_word = 1'b0;
    end else if (beat.code == CodeBspc) begin
      if (word_len > 0) word_len--;
      if (word_len == 0) in_word = 1'b0;
    end else begin
      word_len = 0;
      in_word = 1'b0;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_key(cur_beat);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= GapPct)) begin
          cur_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          key_code <= cur_beat.code;
          key_down <= cur_beat.down;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event code %0d down %0b last %0b", $time,
                   out_code, out_down, out_last);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          events_checked++;
          if (out_code !== want.code) begin
            $display("%0t: out_code expected %0d actual %0d", $time, want.code, out_code);
            mismatches++;
          end
          if (out_down !== want.down) begin
            $display("%0t: out_down expected %0b actual %0b", $time, want.down, out_down);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
            mismatches++;
          end
        end
      end
      // one long hold-off so the engine backs up into its input
      if (hold_phase && !hold_done && out_valid) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < GapPct);
      end
    end
  end

  task automatic queue_beat(input hid_code_t code, input logic down);
    pending_beats.push_back(key_beat_t'{code, down});
    beats_queued++;
  endtask

  function automatic hid_code_t any_letter();
    return 8'(CodeA + $urandom_range(25));
  endfunction

  function automatic hid_code_t any_boundary();
    return boundary_keys[$urandom_range(4)];
  endfunction

  // press the letters of a word, releasing some, with an optional slip fixed by backspace
  task automatic type_text(input string w, input int slip_at, input int release_pct);
    hid_code_t c;
    for (int i = 0; i < w.len(); i++) begin
      if (i == slip_at) begin
        queue_beat(any_letter(), 1'b1);
        queue_beat(CodeBspc, 1'b1);
      end
      c = 8'(CodeA + (8'(w[i]) - AsciiA));
      queue_beat(c, 1'b1);
      if ($urandom_range(99) < release_pct) queue_beat(c, 1'b0);
    end
  endtask

  // half real typing of typos, plus correct words, near misses, noise, broken and overlong words
  task automatic queue_typing(input int count);
    int    target;
    int    pick;
    int    n;
    string w;
    target = beats_queued + count;
    while (beats_queued < target) begin
      pick = $urandom_range(99);
      w = typo_words[$urandom_range(TableEntries - 1)];
      if (pick < 50) begin
        type_text(w, ($urandom_range(3) == 0) ? int'($urandom_range(w.len() - 1)) : -1, 40);
        if ($urandom_range(4) == 0) queue_beat(any_boundary(), 1'b0);
        queue_beat(any_boundary(), 1'b1);
      end else if (pick < 60) begin
        type_text(fix_words[$urandom_range(TableEntries - 1)], -1, 30);
        queue_beat(any_boundary(), 1'b1);
      end else if (pick < 72) begin
        // near miss: one letter changed, one added or one dropped
        case ($urandom_range(2))
          0: w[$urandom_range(w.len() - 1)] = byte'(AsciiA + $urandom_range(25));
          1: w = {w, "e"};
          default: w = w.substr(0, w.len() - 2);
        endcase
        type_text(w, -1, 20);
        queue_beat(any_boundary(), 1'b1);
      end else if (pick < 82) begin
        n = $urandom_range(12, 1);
        for (int i = 0; i < n; i++) queue_beat(any_letter(), 1'b1);
        queue_beat(any_boundary(), 1'b1);
      end else if (pick < 92) begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) queue_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 96) begin
        // word broken by another key, sometimes with a backspace on the emptied word, then retyped
        type_text(w.substr(0, 1), -1, 0);
        queue_beat(($urandom_range(1) == 0) ? 8'd57 : 8'($urandom_range(255, 56)), 1'b1);
        if ($urandom_range(1) == 0) queue_beat(CodeBspc, 1'b1);
        type_text(w, -1, 0);
        queue_beat(any_boundary(), 1'b1);
      end else begin
        // buffer filled near or past full, sometimes erased back to empty or past it before a typo
        n = $urandom_range(36, 28);
        for (int i = 0; i < n; i++) queue_beat(any_letter(), 1'b1);
        if ($urandom_range(1) == 0) begin
          for (int i = 0; i < n; i++) queue_beat(CodeBspc, 1'b1);
          type_text(w, -1, 0);
        end
        queue_beat(any_boundary(), 1'b1);
      end
    end
  endtask

  // wait for every beat to go in and every event to come out
  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || expected_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_min_len(input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= 5'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    min_len = value;
    settings_used++;
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_min_len(3);

    // directed: release, empty backspace, each boundary, unknown keys, short word
    queue_beat(CodeA, 1'b0);
    queue_beat(CodeBspc, 1'b1);
    type_text("teh", -1, 0);
    queue_beat(CodeSpace, 1'b1);
    type_text("adnx", -1, 0);
    queue_beat(CodeBspc, 1'b1);
    queue_beat(CodeComma, 1'b1);
    queue_beat(8'd0, 1'b1);
    queue_beat(8'd255, 1'b1);
    queue_beat(CodeZ, 1'b1);
    queue_beat(CodeA, 1'b1);
    queue_beat(CodeRet, 1'b1);
    type_text("taht", -1, 0);
    queue_beat(CodeDot, 1'b1);
    type_text("teh", -1, 0);
    queue_beat(CodeTab, 1'b1);
    settle();

    // random phases over several length settings
    set_min_len(1);
    hold_phase = 1'b1;
    queue_typing(69);
    settle();
    hold_phase = 1'b0;

    set_min_len(8);
    steady = 1'b1;
    queue_typing(69);
    settle();
    steady = 1'b0;

    set_min_len(31);
    queue_typing(69);
    settle();

    set_min_len(int'($urandom_range(10, 1)));
    queue_typing(69);
    settle();

    set_min_len(3);
    queue_typing(69);
    settle();

    $display("%0d key beats sent under %0d length settings, %0d events checked, %0d fixes",
             beats_sent, settings_used, events_checked, fixes_predicted);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("timeout with %0d events outstanding", expected_events.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
